[rtl/blm_pkg.sv]
package blm_pkg;

	// field widths fixed by the interface
	localparam int LEN_W = 5;
	localparam int IDX_OUT_W = 6;
	localparam int ENTRY_W = 6;
	localparam int ALLOW_W = 5;
	localparam int COUNT_W = 7;

	// configuration register indexes
	localparam logic REG_ALLOWED = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT
	} state_t;

	// score of one library entry against the query
	typedef struct packed {
		logic exact;
		logic [LEN_W-1:0] score;
	} score_t;

endpackage

[rtl/blm_ram.sv]
module blm_ram #(
	parameter int WIDTH = 53,
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/blm_score.sv]
module blm_score #(
	parameter int MAX_LEN = 16
) (
	input logic [3*MAX_LEN-1:0] q_bases,
	input logic [blm_pkg::LEN_W-1:0] q_len,
	input logic [3*MAX_LEN-1:0] e_bases,
	input logic [blm_pkg::LEN_W-1:0] e_len,
	input logic allow_zero,
	output blm_pkg::score_t result
);
	import blm_pkg::*;

	logic eq_len;
	logic [MAX_LEN-1:0] mism;
	logic [3*MAX_LEN-1:0] lng, sht;
	logic [LEN_W-1:0] llen, slen;
	logic [MAX_LEN:0] hit;
	logic sub;

	assign eq_len = (e_len == q_len);

	// per-base mismatch flags; bases past the length are stored as zero
	always_comb begin
		for (int j = 0; j < MAX_LEN; j++) begin
			mism[j] = (q_bases[3*j +: 3] != e_bases[3*j +: 3]);
		end
	end

	// order the pair as longer and shorter
	always_comb begin
		if (q_len > e_len) begin
			lng = q_bases;
			llen = q_len;
			sht = e_bases;
			slen = e_len;
		end else begin
			lng = e_bases;
			llen = e_len;
			sht = q_bases;
			slen = q_len;
		end
	end

	// substring test at every offset in parallel
	always_comb begin
		for (int o = 0; o <= MAX_LEN; o++) begin
			hit[o] = ((o + int'(slen)) <= int'(llen));
			for (int j = 0; j < MAX_LEN; j++) begin
				if (j >= int'(slen)) begin
					hit[o] = hit[o];
				end else if (o + j < MAX_LEN) begin
					if (lng[3*(o+j) +: 3] != sht[3*j +: 3]) begin
						hit[o] = 1'b0;
					end
				end else begin
					hit[o] = 1'b0;
				end
			end
		end
		sub = |hit;
	end

	always_comb begin
		result.exact = eq_len && (mism == '0);
		if (eq_len) begin
			result.score = allow_zero ? q_len : LEN_W'($countones(mism));
		end else begin
			result.score = sub ? '0 : q_len;
		end
	end

endmodule

[rtl/barcode_library_match_core.sv]
// Barcode library matcher.
// Input channel (valid/ready): cmd 0 loads seq_bases/seq_length into slot
// entry_index of the library; cmd 1 queries a sequence. A load gives no
// result and leaves the core idle, so loads can follow each other every
// cycle while no query is in work. A query gives one result (found,
// match_index) on the output channel. The scan searches library_count
// entries, saturated to LIB_DEPTH, up to and including the first exact
// match. Each entry passes the read issue, the memory read and the scoring
// stage; the result is then registered and moved to the output register.
// An empty library skips the scan and goes straight to the output register.
// One request is in work at a time; ready stays low from an accepted query
// until its result moves to the output register. Ready is high while idle,
// also while a finished result still waits on the output register. If the
// receiver stalls, the result holds in the output register and a further
// finished query waits in its own state, with ready low, until the register
// frees.
// APB port: register 0 allowed_mismatches at 0x0, register 1 library_count
// at 0x4; write only while idle.
// Reset clears control state and sets allowed_mismatches to 1 and
// library_count to 0. Library contents are undefined until loaded.
module barcode_library_match_core #(
	parameter int MAX_LEN = 16,
	parameter int LIB_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [0:0] cmd,
	input logic [blm_pkg::ENTRY_W-1:0] entry_index,
	input logic [3*MAX_LEN-1:0] seq_bases,
	input logic [blm_pkg::LEN_W-1:0] seq_length,
	output logic out_valid,
	input logic out_ready,
	output logic [0:0] found,
	output logic [blm_pkg::IDX_OUT_W-1:0] match_index,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import blm_pkg::*;

	localparam int AW = (LIB_DEPTH > 1) ? $clog2(LIB_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIB_DEPTH + 1);
	localparam int BW = 3 * MAX_LEN;
	localparam int RW = BW + LEN_W;

	state_t state_q, state_d;

	logic [ALLOW_W-1:0] allowed_q;
	logic [COUNT_W-1:0] count_reg_q;

	logic [BW-1:0] q_bases_q;
	logic [LEN_W-1:0] q_len_q;
	logic [CNT_W-1:0] count_q;

	logic [CNT_W-1:0] rd_cnt_q;
	logic [AW-1:0] idx_s1, idx_s2;
	logic vld_s1, vld_s2;
	score_t score_s2;

	logic have_q, uniq_q;
	logic [LEN_W-1:0] best_q;
	logic [AW-1:0] bidx_q;
	logic res_found_q;
	logic [AW-1:0] res_idx_q;

	// input sequence: clamp length, zero bases past it
	logic [LEN_W-1:0] in_len;
	logic [BW-1:0] in_bases;
	always_comb begin
		in_len = (seq_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : seq_length;
		for (int j = 0; j < MAX_LEN; j++) begin
			in_bases[3*j +: 3] = (j < int'(in_len)) ? seq_bases[3*j +: 3] : 3'b000;
		end
	end

	logic in_acc, out_acc, cfg_wr;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= ALLOW_W'(1);
			count_reg_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ALLOWED) begin
				allowed_q <= pwdata[ALLOW_W-1:0];
			end else begin
				count_reg_q <= pwdata[COUNT_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_ALLOWED) ? 32'(allowed_q) : 32'(count_reg_q);

	// library memory: bases and length per entry
	logic [AW+ENTRY_W-1:0] slot_ext;
	logic ram_we;
	logic [AW-1:0] raddr;
	logic [RW-1:0] rdata;
	assign slot_ext = {{AW{1'b0}}, entry_index};
	assign ram_we = in_acc && (cmd == CMD_LOAD) && (32'(entry_index) < LIB_DEPTH);
	assign raddr = rd_cnt_q[AW-1:0];

	blm_ram #(
		.WIDTH(RW),
		.DEPTH(LIB_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(slot_ext[AW-1:0]),
		.wdata({in_len, in_bases}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// score the entry read last cycle
	score_t score_c;
	blm_score #(
		.MAX_LEN(MAX_LEN)
	) u_score (
		.q_bases(q_bases_q),
		.q_len(q_len_q),
		.e_bases(rdata[BW-1:0]),
		.e_len(rdata[RW-1:BW]),
		.allow_zero(allowed_q == '0),
		.result(score_c)
	);

	// saturated entry count for a new query
	logic [CNT_W-1:0] count_sat;
	assign count_sat = (32'(count_reg_q) > LIB_DEPTH) ? CNT_W'(LIB_DEPTH)
		: CNT_W'(count_reg_q);

	// running minimum, including the entry now at stage two
	logic nhave, nuniq;
	logic [LEN_W-1:0] nbest;
	logic [AW-1:0] nbidx;
	logic last_s2, done;
	always_comb begin
		nhave = have_q;
		nuniq = uniq_q;
		nbest = best_q;
		nbidx = bidx_q;
		if (vld_s2) begin
			if (!have_q || score_s2.score < best_q) begin
				nhave = 1'b1;
				nuniq = 1'b1;
				nbest = score_s2.score;
				nbidx = idx_s2;
			end else if (score_s2.score == best_q) begin
				nuniq = 1'b0;
				nbidx = idx_s2;
			end
		end
		last_s2 = vld_s2 && (CNT_W'(idx_s2) == count_q - CNT_W'(1));
		done = vld_s2 && (score_s2.exact || last_s2);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd == CMD_QUERY) begin
					state_d = (count_sat == '0) ? ST_WAIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (done) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!out_valid || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// query latch
	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_QUERY) begin
			q_bases_q <= in_bases;
			q_len_q <= in_len;
			count_q <= count_sat;
		end
	end

	// read issue and scoring pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			have_q <= 1'b0;
			uniq_q <= 1'b0;
		end else if (state_q != ST_SCAN || done) begin
			rd_cnt_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			have_q <= 1'b0;
			uniq_q <= 1'b0;
		end else begin
			vld_s1 <= (rd_cnt_q < count_q);
			if (rd_cnt_q < count_q) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			vld_s2 <= vld_s1;
			have_q <= nhave;
			uniq_q <= nuniq;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= raddr;
		idx_s2 <= idx_s1;
		score_s2 <= score_c;
		best_q <= nbest;
		bidx_q <= nbidx;
	end

	// final result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			res_found_q <= 1'b0;
			res_idx_q <= '0;
		end else if (state_q == ST_SCAN && done) begin
			if (score_s2.exact) begin
				res_found_q <= 1'b1;
				res_idx_q <= idx_s2;
			end else if (nhave && nuniq && (ALLOW_W'(nbest) <= allowed_q)) begin
				res_found_q <= 1'b1;
				res_idx_q <= nbidx;
			end else begin
				res_found_q <= 1'b0;
				res_idx_q <= '0;
			end
		end
	end

	// output register
	logic [AW+IDX_OUT_W-1:0] res_ext;
	assign res_ext = {{IDX_OUT_W{1'b0}}, res_idx_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_WAIT && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_acc) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && (!out_valid || out_ready)) begin
			found <= res_found_q;
			match_index <= res_ext[IDX_OUT_W-1:0];
		end
	end

	a_no_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !in_ready)
		else $error("input taken during scan");
	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 || vld_s2) |-> (state_q == ST_SCAN))
		else $error("scan pipeline busy outside scan");
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= count_q))
		else $error("read past library count");
	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (match_index == '0))
		else $error("index set without match");

endmodule

[bench/barcode_library_match_checker.sv]
`timescale 1ns / 100ps

// Watches the request, result and APB channels, predicts each query result
// and compares it with what the core returns.
module barcode_library_match_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [0:0] cmd,
	input logic [5:0] entry_index,
	input logic [47:0] seq_bases,
	input logic [4:0] seq_length,
	input logic out_valid,
	input logic out_ready,
	input logic [0:0] found,
	input logic [5:0] match_index,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int fail_count,
	output int pending_count
);
	import blm_pkg::*;

	typedef struct packed {
		logic found;
		logic [5:0] idx;
	} match_t;

	match_t expected_matches[$];
	logic [47:0] lib_bases[64];
	logic [4:0] lib_lens[64];
	logic [4:0] allow_reg;
	logic [6:0] count_reg;

	assign pending_count = expected_matches.size();

	function automatic logic [4:0] sat_len(logic [4:0] l);
		return (l > 16) ? 5'd16 : l;
	endfunction

	function automatic logic [47:0] keep_bases(logic [47:0] b, logic [4:0] l);
		logic [47:0] m;
		m = '0;
		for (int i = 0; i < l; i++) m[3*i +: 3] = 3'b111;
		return b & m;
	endfunction

	// true if sht (slen bases) occurs somewhere in lng (llen bases)
	function automatic bit has_substr(logic [47:0] lng, int llen, logic [47:0] sht, int slen);
		logic [47:0] win;
		for (int o = 0; o + slen <= llen; o++) begin
			win = keep_bases(lng >> (3*o), slen[4:0]);
			if (win == sht) return 1;
		end
		return 0;
	endfunction

	function automatic match_t score_query(logic [47:0] q, logic [4:0] qlen);
		match_t r;
		int n, best, nbest, bidx, sc, elen;
		bit have;
		logic [47:0] e;
		r = '0;
		have = 0; best = 0; nbest = 0; bidx = 0;
		n = (count_reg > 64) ? 64 : count_reg;
		for (int i = 0; i < n; i++) begin
			elen = sat_len(lib_lens[i]);
			e = keep_bases(lib_bases[i], elen[4:0]);
			if (elen == qlen && e == q) begin
				r.found = 1;
				r.idx = i[5:0];
				return r;
			end
			if (elen == qlen) begin
				if (allow_reg == 0) sc = qlen;
				else begin
					sc = 0;
					for (int b = 0; b < qlen; b++)
						if (q[3*b +: 3] != e[3*b +: 3]) sc++;
				end
			end else begin
				if (qlen > elen) sc = has_substr(q, qlen, e, elen) ? 0 : qlen;
				else sc = has_substr(e, elen, q, qlen) ? 0 : qlen;
			end
			if (!have || sc < best) begin
				have = 1; best = sc; nbest = 1; bidx = i;
			end else if (sc == best) begin
				nbest++; bidx = i;
			end
		end
		if (have && best <= allow_reg && nbest == 1) begin
			r.found = 1;
			r.idx = bidx[5:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [4:0] l;
		match_t exp_m;
		if (!arst_n) begin
			allow_reg <= 5'd1;
			count_reg <= '0;
			fail_count <= 0;
			expected_matches.delete();
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_ALLOWED) allow_reg <= pwdata[4:0];
				else count_reg <= pwdata[6:0];
			end
			// accepted request
			if (in_valid && in_ready) begin
				l = sat_len(seq_length);
				if (cmd == CMD_LOAD) begin
					lib_bases[entry_index] = keep_bases(seq_bases, l);
					lib_lens[entry_index] = l;
				end else begin
					expected_matches = {expected_matches,
						score_query(keep_bases(seq_bases, l), l)};
				end
			end
			// accepted result
			if (out_valid && out_ready) begin
				if (expected_matches.size() == 0) begin
					$error("unexpected result found=%0d match_index=%0d", found, match_index);
					fail_count <= fail_count + 1;
				end else begin
					exp_m = expected_matches.pop_front();
					if (found !== exp_m.found) begin
						$error("found: expected %0d, got %0d", exp_m.found, found);
						fail_count <= fail_count + 1;
					end else if (match_index !== exp_m.idx) begin
						$error("match_index: expected %0d, got %0d", exp_m.idx, match_index);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[bench/barcode_library_match_core_test.sv]
`timescale 1ns / 100ps

module barcode_library_match_core_test;
	import blm_pkg::*;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready;
	logic [0:0] cmd = 0;
	logic [5:0] entry_index = 0;
	logic [47:0] seq_bases = 0;
	logic [4:0] seq_length = 0;
	logic out_valid, out_ready = 0;
	logic [0:0] found;
	logic [5:0] match_index;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	int fail_count, pending_count;
	int cycles = 0;
	bit sink_calm = 0;
	bit src_calm = 0;
	int lib_size = 0;
	logic [47:0] shadow_bases[64];
	logic [4:0] shadow_lens[64];

	barcode_library_match_core dut (.*);
	barcode_library_match_checker chk (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result receiver with stall bursts
	initial begin
		int k;
		forever begin
			@(negedge clk);
			if (sink_calm || $urandom_range(3) != 0) out_ready <= 1;
			else begin
				k = $urandom_range(1, 10);
				out_ready <= 0;
				repeat (k - 1) @(negedge clk);
			end
		end
	end

	task automatic apb_write(logic idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_count != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// valid stays high after an accept until the next request, an idle
	// burst or a drain takes over at that same falling edge
	task automatic send_request(logic c, logic [5:0] slot, logic [47:0] b, logic [4:0] l);
		if (!src_calm && $urandom_range(4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		cmd <= c; entry_index <= slot; seq_bases <= b; seq_length <= l;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		if (c == CMD_LOAD) begin
			shadow_bases[slot] = b;
			shadow_lens[slot] = l;
		end
	endtask

	function automatic logic [47:0] rand_bases();
		logic [47:0] b;
		b = {$urandom, $urandom};
		// mostly proper codes, sometimes odd codes 4..7
		if ($urandom_range(3) != 0)
			for (int i = 0; i < 16; i++) b[3*i +: 3] = 3'($urandom_range(0, 3));
		return b;
	endfunction

	// query derived from a loaded entry: copy, mutate, slice or extend it
	task automatic send_related_query();
		int s, l, o;
		logic [47:0] b;
		s = $urandom_range(0, lib_size - 1);
		b = shadow_bases[s];
		l = shadow_lens[s] > 16 ? 16 : shadow_lens[s];
		case ($urandom_range(3))
			0: ;
			1: repeat ($urandom_range(1, 3))
				b[3*$urandom_range(0, 15) +: 3] = 3'($urandom_range(0, 4));
			2: begin
				o = (l > 0) ? $urandom_range(0, l - 1) : 0;
				b = b >> (3*o);
				l = $urandom_range(0, l - o);
			end
			default: begin
				b = (b << 6) | (rand_bases() & 48'h3F);
				l = (l + 2 > 16) ? 16 : l + 2;
			end
		endcase
		send_request(CMD_QUERY, 6'($urandom), b, l[4:0]);
	endtask

	task automatic load_library(int n, int maxlen);
		for (int i = 0; i < n; i++)
			send_request(CMD_LOAD, i[5:0], rand_bases(), 5'($urandom_range(0, maxlen)));
		lib_size = n > lib_size ? n : lib_size;
	endtask

	initial begin
		int n;
		repeat (12) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: empty library, then a full library with extremes
		send_request(CMD_QUERY, 6'd0, 48'h0, 5'd0);
		drain();
		send_request(CMD_LOAD, 6'd0, 48'h0, 5'd0);
		send_request(CMD_LOAD, 6'd1, 48'hFFFF_FFFF_FFFF, 5'd31);
		send_request(CMD_LOAD, 6'd2, 48'h000000_00A4C8, 5'd4);
		send_request(CMD_LOAD, 6'd63, 48'hFFFF_FFFF_FFFF, 5'd16);
		for (int i = 3; i < 63; i++)
			send_request(CMD_LOAD, i[5:0], rand_bases(), 5'd16);
		lib_size = 64;
		drain();
		apb_write(REG_COUNT, 32'd127);
		apb_write(REG_ALLOWED, 32'd16);
		send_request(CMD_QUERY, 6'd5, 48'h0, 5'd0);
		send_request(CMD_QUERY, 6'd63, 48'hFFFF_FFFF_FFFF, 5'd20);
		send_request(CMD_QUERY, 6'd0, 48'h000000_0000C8, 5'd2);
		send_request(CMD_QUERY, 6'd0, 48'hFFFF_FFFF_FFFF, 5'd15);
		drain();
		apb_write(REG_ALLOWED, 32'd0);
		send_request(CMD_QUERY, 6'd0, shadow_bases[7] ^ 48'h7, 5'd16);
		send_request(CMD_QUERY, 6'd0, 48'h000000_00A4C8, 5'd4);
		drain();
		apb_write(REG_COUNT, 32'd1);
		send_request(CMD_QUERY, 6'd0, 48'h5, 5'd1);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 12; ph++) begin
			drain();
			n = (ph % 4 == 0) ? 64 : $urandom_range(1, 12);
			apb_write(REG_ALLOWED, (ph == 1) ? 0 : (ph == 2) ? 16 : $urandom_range(0, 4));
			apb_write(REG_COUNT, (ph == 3) ? 0 : (ph == 5) ? 100 : n);
			load_library(n, (ph % 3 == 0) ? 20 : 16);
			if (ph >= 10) begin
				src_calm = 1; sink_calm = 1;
			end
			for (int k = 0; k < 80; k++) begin
				if ($urandom_range(9) == 0)
					send_request(CMD_LOAD, 6'($urandom_range(0, n - 1)), rand_bases(),
						5'($urandom_range(0, 16)));
				else if ($urandom_range(3) == 0)
					send_request(CMD_QUERY, 6'($urandom), rand_bases(), 5'($urandom));
				else send_related_query();
				if (k == 40) begin
					in_valid <= 0;
					while (pending_count != 0) @(negedge clk);
				end
			end
		end
		drain();
		if (fail_count == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
